// ----- sv/arm_mode_bank_exception_unit_core_assert.svh -----
`ifndef ARM_MODE_BANK_EXCEPTION_UNIT_CORE_ASSERT_SVH
`define ARM_MODE_BANK_EXCEPTION_UNIT_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define ARM_MBX_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define ARM_MBX_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/arm_mbx_pkg.sv -----
`timescale 1ns / 1ps
package arm_mbx_pkg;

	localparam int NUM_BANKS_DEF = 6;
	localparam int SLOTS         = 7;
	localparam int BANK_W        = $clog2(NUM_BANKS_DEF);
	localparam int SLOT_W        = $clog2(SLOTS);

	typedef enum logic [2:0] {
		OP_WRITE = 3'd0,
		OP_READ  = 3'd1,
		OP_MODE  = 3'd2,
		OP_IRQ   = 3'd3,
		OP_SWI   = 3'd4,
		OP_UND   = 3'd5,
		OP_HALT  = 3'd6,
		OP_NOP   = 3'd7
	} op_t;

	localparam logic [4:0] MODE_USR  = 5'h10;
	localparam logic [4:0] MODE_FAST = 5'h11;
	localparam logic [4:0] MODE_INTR = 5'h12;
	localparam logic [4:0] MODE_SVC  = 5'h13;
	localparam logic [4:0] MODE_ABT  = 5'h17;
	localparam logic [4:0] MODE_UND  = 5'h1B;
	localparam logic [4:0] MODE_SYS  = 5'h1F;

	localparam logic [4:0] REG_CPSR = 5'd16;
	localparam logic [4:0] REG_SPSR = 5'd17;

	localparam int BIT_T = 5;
	localparam int BIT_I = 7;

	localparam logic [BANK_W-1:0] BANK_USR  = BANK_W'(0);
	localparam logic [BANK_W-1:0] BANK_FAST = BANK_W'(1);
	localparam logic [BANK_W-1:0] BANK_IRQ  = BANK_W'(2);
	localparam logic [BANK_W-1:0] BANK_SVC  = BANK_W'(3);
	localparam logic [BANK_W-1:0] BANK_ABT  = BANK_W'(4);
	localparam logic [BANK_W-1:0] BANK_UND  = BANK_W'(5);

	localparam logic [31:0] HIGH_BASE = 32'hFFFF_0000;
	localparam logic [31:0] RESET_PC  = 32'd4;
	// vector plus pipeline offset
	localparam logic [31:0] PC_IRQ    = 32'h0000_001C;
	localparam logic [31:0] PC_SVC    = 32'h0000_000C;
	localparam logic [31:0] PC_UND    = 32'h0000_0008;

	// link offset: extra minus instruction width
	localparam logic signed [3:0] LR_OFF_IRQ_ARM   = 4'sd0;
	localparam logic signed [3:0] LR_OFF_IRQ_THUMB = 4'sd2;
	localparam logic signed [3:0] LR_OFF_ARM       = -4'sd4;
	localparam logic signed [3:0] LR_OFF_THUMB     = -4'sd2;

	function automatic logic [BANK_W-1:0] bank_of(input logic [4:0] m);
		logic [BANK_W-1:0] b;
		case (m)
			MODE_USR, MODE_SYS: b = BANK_USR;
			MODE_FAST: b = BANK_FAST;
			MODE_INTR: b = BANK_IRQ;
			MODE_SVC: b = BANK_SVC;
			MODE_ABT: b = BANK_ABT;
			MODE_UND: b = BANK_UND;
			default:  b = BANK_USR;
		endcase
		return b;
	endfunction

	function automatic logic mode_known(input logic [4:0] m);
		logic k;
		case (m)
			MODE_USR, MODE_SYS, MODE_FAST, MODE_INTR,
			MODE_SVC, MODE_ABT, MODE_UND: k = 1'b1;
			default: k = 1'b0;
		endcase
		return k;
	endfunction

	// bank slot to register: 0 sp, 1 lr, 2..6 r8..r12
	function automatic logic [3:0] slot_reg(input logic [SLOT_W-1:0] s);
		logic [3:0] r;
		if (s < SLOT_W'(2)) begin
			r = 4'd13 + {3'b000, s[0]};
		end else begin
			r = 4'({1'b0, s}) + 4'd6;
		end
		return r;
	endfunction

endpackage

// ----- sv/arm_mode_bank_exception_unit_core.sv -----
`timescale 1ns / 1ps
// ARM mode banking and exception entry unit.
// Command channel: an item (opcode, reg_index, write_value, new_mode) is taken
// at a clock edge with start high and busy low. busy stays high until the
// result has been produced.
// Result channel: done is high for one cycle with read_data, status_word,
// irq_taken, halted_now and bad_mode valid; the receiver cannot stall, so a
// new item may be started in the same cycle that done is shown.
// Config channel: cfg_valid/cfg_ready/cfg_data write high_vectors; cfg_ready
// is always high. Write it only while the unit is idle.
// Sequence: an item with no bank exchange goes from idle to the finishing
// state and back. A mode switch or exception that changes bank moves sp/lr
// through the write and read ports of the bank memory, one slot per cycle,
// and r8-r12 as well when fiq is entered or left.
// Reset: pc = 4, cpsr = system mode in arm state, all banks and registers
// zero, high_vectors clear. No clearing pass is needed after reset.
module arm_mode_bank_exception_unit_core #(
	parameter int NUM_BANKS = arm_mbx_pkg::NUM_BANKS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  opcode,
	input  logic [4:0]  reg_index,
	input  logic [31:0] write_value,
	input  logic [4:0]  new_mode,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data,
	output logic        done,
	output logic [31:0] read_data,
	output logic [31:0] status_word,
	output logic        irq_taken,
	output logic        halted_now,
	output logic        bad_mode
);

	import arm_mbx_pkg::*;

	localparam int DEPTH = NUM_BANKS * SLOTS;
	localparam int AW    = $clog2(DEPTH);
	localparam int BW    = $clog2(NUM_BANKS);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SWAP,
		S_WB,
		S_FIN
	} state_t;

	state_t            state_q;
	op_t               op_q;
	logic [4:0]        idx_q;
	logic [31:0]       val_q;
	logic [4:0]        nm_q;
	logic [4:0]        mode_q;
	logic              sw_q;
	logic              bad_q;
	logic              irq_ok_q;
	logic [BW-1:0]     ob_q;
	logic [BW-1:0]     nb_q;
	logic [SLOT_W-1:0] slot_q;
	logic [SLOT_W-1:0] last_q;
	logic              wb_pend_q;
	logic [3:0]        wb_reg_q;

	logic [31:0] regs_q [16];
	logic [31:0] sbs_q [NUM_BANKS];
	logic [31:0] cpsr_q;
	logic [31:0] spsr_q;
	logic [4:0]  active_q;
	logic        halt_q;
	logic        hv_q;

	logic        done_q;
	logic [31:0] rd_q;
	logic [31:0] status_q;
	logic        taken_q;
	logic        halted_q;
	logic        bad_out_q;

	op_t           op_in;
	logic          accept;
	logic [4:0]    sw_mode_c;
	logic          do_sw_c;
	logic [BW-1:0] nb_c;
	logic [BW-1:0] ob_c;
	logic          need_bank_c;
	logic          fiq_c;
	logic [BW-1:0] wr_bank_c;
	logic [BW-1:0] rd_bank_c;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [AW-1:0] mem_raddr;
	logic [31:0]   mem_rdata;
	logic [3:0]    rf_raddr;
	logic [31:0]   rf_rdata;

	logic signed [3:0] lr_off_c;
	logic [31:0]       lr_sum;
	logic [31:0]       exc_pc_c;
	logic              exc_c;
	logic [31:0]       cpsr_nxt;
	logic              halt_nxt;
	logic [31:0]       rd_c;

	assign op_in     = op_t'(opcode);
	assign busy      = (state_q != S_IDLE);
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;

	// which mode the item switches to, decided from the command ports
	always_comb begin
		sw_mode_c = MODE_SYS;
		do_sw_c   = 1'b0;
		case (op_in)
			OP_WRITE: begin
				if (reg_index == REG_CPSR) begin
					do_sw_c   = 1'b1;
					sw_mode_c = write_value[4:0];
				end
			end
			OP_MODE: begin
				do_sw_c   = 1'b1;
				sw_mode_c = new_mode;
			end
			OP_IRQ: begin
				do_sw_c   = !cpsr_q[BIT_I];
				sw_mode_c = MODE_INTR;
			end
			OP_SWI: begin
				do_sw_c   = 1'b1;
				sw_mode_c = MODE_SVC;
			end
			OP_UND: begin
				do_sw_c   = 1'b1;
				sw_mode_c = MODE_UND;
			end
			default: ;
		endcase
	end

	assign nb_c        = BW'(bank_of(sw_mode_c));
	assign ob_c        = BW'(bank_of(active_q));
	assign need_bank_c = do_sw_c && (sw_mode_c != active_q) && (nb_c != ob_c);
	assign fiq_c       = (nb_c == BW'(BANK_FAST)) || (ob_c == BW'(BANK_FAST));

	// r8-r12 only live in the user copy or the fiq copy
	assign wr_bank_c = (slot_q < SLOT_W'(2)) ? ob_q :
		((ob_q == BW'(BANK_FAST)) ? BW'(BANK_FAST) : BW'(BANK_USR));
	assign rd_bank_c = (slot_q < SLOT_W'(2)) ? nb_q :
		((nb_q == BW'(BANK_FAST)) ? BW'(BANK_FAST) : BW'(BANK_USR));

	// one slot per cycle: save old bank, fetch new bank
	assign mem_we    = (state_q == S_SWAP);
	assign mem_waddr = AW'(wr_bank_c) * AW'(SLOTS) + AW'(slot_q);
	assign mem_raddr = AW'(rd_bank_c) * AW'(SLOTS) + AW'(slot_q);
	assign rf_raddr  = (state_q == S_SWAP) ? slot_reg(slot_q) : idx_q[3:0];
	assign rf_rdata  = regs_q[rf_raddr];

	arm_mbx_bank_mem #(
		.DEPTH(DEPTH)
	) u_bank_mem (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (rf_rdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_comb begin
		if (op_q == OP_IRQ) begin
			lr_off_c = cpsr_q[BIT_T] ? LR_OFF_IRQ_THUMB : LR_OFF_IRQ_ARM;
		end else begin
			lr_off_c = cpsr_q[BIT_T] ? LR_OFF_THUMB : LR_OFF_ARM;
		end
	end

	arm_mbx_alu u_alu (
		.a  (regs_q[15]),
		.off(lr_off_c),
		.sum(lr_sum)
	);

	assign exc_c = ((op_q == OP_IRQ) && irq_ok_q) || (op_q == OP_SWI) || (op_q == OP_UND);

	always_comb begin
		case (op_q)
			OP_IRQ:  exc_pc_c = PC_IRQ;
			OP_SWI:  exc_pc_c = PC_SVC;
			default: exc_pc_c = PC_UND;
		endcase
		if (hv_q) begin
			exc_pc_c = exc_pc_c | HIGH_BASE;
		end
	end

	// final effect of the item, applied in the finishing cycle
	always_comb begin
		cpsr_nxt = cpsr_q;
		halt_nxt = halt_q;
		rd_c     = '0;
		case (op_q)
			OP_WRITE: begin
				if (idx_q == REG_CPSR) begin
					cpsr_nxt = val_q;
				end
			end
			OP_READ: begin
				if (!idx_q[4]) begin
					rd_c = rf_rdata;
				end else if (idx_q == REG_CPSR) begin
					rd_c = cpsr_q;
				end else if (idx_q == REG_SPSR) begin
					rd_c = spsr_q;
				end
			end
			OP_MODE: cpsr_nxt = {cpsr_q[31:5], nm_q};
			OP_HALT: halt_nxt = 1'b1;
			default: ;
		endcase
		if (exc_c) begin
			cpsr_nxt = {cpsr_q[31:8], 1'b1, cpsr_q[6], 1'b0, mode_q};
			if (op_q == OP_IRQ) begin
				halt_nxt = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			op_q      <= OP_NOP;
			idx_q     <= '0;
			val_q     <= '0;
			nm_q      <= '0;
			mode_q    <= MODE_SYS;
			sw_q      <= 1'b0;
			bad_q     <= 1'b0;
			irq_ok_q  <= 1'b0;
			ob_q      <= '0;
			nb_q      <= '0;
			slot_q    <= '0;
			last_q    <= '0;
			wb_pend_q <= 1'b0;
			wb_reg_q  <= '0;
			done_q    <= 1'b0;
			rd_q      <= '0;
			status_q  <= '0;
			taken_q   <= 1'b0;
			halted_q  <= 1'b0;
			bad_out_q <= 1'b0;
		end else begin
			done_q    <= 1'b0;
			wb_pend_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q     <= op_in;
						idx_q    <= reg_index;
						val_q    <= write_value;
						nm_q     <= new_mode;
						mode_q   <= sw_mode_c;
						sw_q     <= do_sw_c;
						bad_q    <= do_sw_c && !mode_known(sw_mode_c);
						irq_ok_q <= !cpsr_q[BIT_I];
						ob_q     <= ob_c;
						nb_q     <= nb_c;
						slot_q   <= '0;
						last_q   <= fiq_c ? SLOT_W'(SLOTS - 1) : SLOT_W'(1);
						state_q  <= need_bank_c ? S_SWAP : S_FIN;
					end
				end
				S_SWAP: begin
					wb_pend_q <= 1'b1;
					wb_reg_q  <= slot_reg(slot_q);
					slot_q    <= slot_q + 1'b1;
					if (slot_q == last_q) begin
						state_q <= S_WB;
					end
				end
				S_WB: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					done_q    <= 1'b1;
					rd_q      <= rd_c;
					status_q  <= cpsr_nxt;
					taken_q   <= (op_q == OP_IRQ) && irq_ok_q;
					halted_q  <= halt_nxt;
					bad_out_q <= bad_q;
					state_q   <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) begin
				regs_q[i] <= (i == 15) ? RESET_PC : '0;
			end
		end else begin
			// bank data arrives in the cycle after its slot was addressed
			if (wb_pend_q) begin
				regs_q[wb_reg_q] <= mem_rdata;
			end
			if (state_q == S_FIN) begin
				if ((op_q == OP_WRITE) && !idx_q[4]) begin
					regs_q[idx_q[3:0]] <= val_q;
				end
				if (exc_c) begin
					regs_q[14] <= lr_sum;
					regs_q[15] <= exc_pc_c;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BANKS; i++) begin
				sbs_q[i] <= '0;
			end
			cpsr_q   <= {27'd0, MODE_SYS};
			spsr_q   <= '0;
			active_q <= MODE_SYS;
			halt_q   <= 1'b0;
			hv_q     <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				hv_q <= cfg_data;
			end
			if (accept && need_bank_c) begin
				sbs_q[ob_c] <= spsr_q;
				spsr_q      <= sbs_q[nb_c];
			end
			if (state_q == S_FIN) begin
				cpsr_q <= cpsr_nxt;
				halt_q <= halt_nxt;
				if (sw_q) begin
					active_q <= mode_q;
				end
				if ((op_q == OP_WRITE) && (idx_q == REG_SPSR)) begin
					spsr_q <= val_q;
				end
				if (exc_c) begin
					spsr_q <= cpsr_q;
				end
			end
		end
	end

	assign done        = done_q;
	assign read_data   = rd_q;
	assign status_word = status_q;
	assign irq_taken   = taken_q;
	assign halted_now  = halted_q;
	assign bad_mode    = bad_out_q;

	`include "arm_mode_bank_exception_unit_core_assert.svh"

	`ARM_MBX_ASSERT_NEXT(a_fin_gives_done, state_q == S_FIN, done, "finishing cycle gave no result")
	`ARM_MBX_ASSERT_NEXT(a_swap_stays_busy, state_q == S_SWAP, (state_q == S_SWAP) || (state_q == S_WB), "bank exchange left early")
	`ARM_MBX_ASSERT(a_irq_enters_irq, done && irq_taken, status_word[BIT_I] && (status_word[4:0] == MODE_INTR), "taken irq not in irq mode with mask set")
	`ARM_MBX_ASSERT(a_bad_mode_unknown, done && bad_mode, !mode_known(status_word[4:0]), "bad mode flagged for a known mode")

endmodule

// ----- sv/arm_mbx_bank_mem.sv -----
`timescale 1ns / 1ps
module arm_mbx_bank_mem #(
	parameter int DEPTH = 42
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [31:0]              wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [31:0]              rdata
);

	logic [31:0]      mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [31:0]      rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// entries never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (we) begin
			valid_q[waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= valid_q[raddr] ? mem[raddr] : '0;
	end

	assign rdata = rdata_q;

endmodule

// ----- sv/arm_mbx_alu.sv -----
`timescale 1ns / 1ps
module arm_mbx_alu (
	input  logic [31:0]       a,
	input  logic signed [3:0] off,
	output logic [31:0]       sum
);

	assign sum = a + {{28{off[3]}}, off};

endmodule
